// ===== hw/rtl/v3n_pkg.sv =====
package v3n_pkg;

    // component widths of the stream formats
    localparam int IN_WIDTH  = 16;
    localparam int OUT_WIDTH = 16;

    // input transaction: signed q8.8 components
    typedef struct packed {
        logic signed [IN_WIDTH-1:0] comp_x;
        logic signed [IN_WIDTH-1:0] comp_y;
        logic signed [IN_WIDTH-1:0] comp_z;
    } vec_in_t;

    // output transaction: signed q1.14 components and zero-length flag
    typedef struct packed {
        logic signed [OUT_WIDTH-1:0] unit_x;
        logic signed [OUT_WIDTH-1:0] unit_y;
        logic signed [OUT_WIDTH-1:0] unit_z;
        logic                        zero_length;
    } vec_out_t;

    // control travelling alongside the data in every pipeline stage
    typedef struct packed {
        logic       valid;
        logic       zero;
        logic [2:0] neg;
    } ctrl_t;

endpackage

// ===== hw/rtl/vector3_normalize_core.sv =====
// channel | signals                          | direction | transaction
// --------+----------------------------------+-----------+-------------------------------
// src     | src_valid, src_ready, src_data   | in        | one vector, q8.8 components
// res     | res_valid, res_ready, res_data   | out       | unit vector q1.14 + zero flag
//
// one vector enters per cycle while res is not stalled; stages in order: magnitude,
// square, sum, one stage per quotient bit of the restoring divider (2*OUT_FRAC_BITS + 3),
// one stage per root bit of the restoring square root (OUT_FRAC_BITS + 2), then the
// output register.
// rst_n clears all valid bits and the output valid asynchronously.
// when res is stalled with a result waiting, the whole pipeline holds and src_ready drops;
// nothing in flight is lost or repeated.
module vector3_normalize_core
    import v3n_pkg::*;
#(
    parameter int OUT_FRAC_BITS = 14
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     src_valid,
    output logic     src_ready,
    input  vec_in_t  src_data,
    output logic     res_valid,
    input  logic     res_ready,
    output vec_out_t res_data
);

    localparam int MW   = IN_WIDTH;
    localparam int SW   = 2 * IN_WIDTH;
    localparam int QW   = 2 * OUT_FRAC_BITS + 3;
    localparam int RW   = OUT_FRAC_BITS + 2;
    localparam int SQW  = 2 * RW;
    localparam int EW   = (RW > OUT_WIDTH) ? RW : OUT_WIDTH;
    localparam int DIV0 = 3;
    localparam int SQ0  = DIV0 + QW;
    localparam int NST  = SQ0 + RW;

    logic adv;

    ctrl_t ctrl_reg [NST];
    ctrl_t ctrl_next;

    logic [MW-1:0] mag_reg      [3];
    logic [SW-1:0] m2_reg       [3];
    logic [SW-1:0] s_reg;
    logic [SW-1:0] init_rem_reg [3];
    logic [2:0]    init_bit_reg;

    logic [SW-1:0] dv_rem_reg [QW][3];
    logic [QW-1:0] dv_quo_reg [QW][3];
    logic [SW-1:0] dv_s_reg   [QW];

    logic [SQW-1:0] sq_rad_reg  [RW][3];
    logic [RW-1:0]  sq_root_reg [RW][3];
    logic [RW+1:0]  sq_rem_reg  [RW][3];

    logic           res_valid_reg;
    vec_out_t       res_data_reg;
    vec_out_t       res_data_next;

    logic signed [IN_WIDTH-1:0] comp [3];

    // whole pipeline moves when the output register is free or being drained
    assign adv       = !res_valid_reg || res_ready;
    assign src_ready = adv;
    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    assign comp[0] = src_data.comp_x;
    assign comp[1] = src_data.comp_y;
    assign comp[2] = src_data.comp_z;

    // control for a new transaction
    always_comb
    begin
        ctrl_next.valid = src_valid;
        ctrl_next.zero  = (src_data.comp_x == '0) && (src_data.comp_y == '0)
                          && (src_data.comp_z == '0);
        ctrl_next.neg   = {src_data.comp_z[IN_WIDTH-1], src_data.comp_y[IN_WIDTH-1],
                           src_data.comp_x[IN_WIDTH-1]};
    end

    // control shift line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < NST; j++)
            begin
                ctrl_reg[j] <= '0;
            end
        end
        else if (adv)
        begin
            ctrl_reg[0] <= ctrl_next;
            for (int j = 1; j < NST; j++)
            begin
                ctrl_reg[j] <= ctrl_reg[j-1];
            end
        end
    end

    // magnitude, square and sum of squares
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                mag_reg[i]      <= comp[i][IN_WIDTH-1] ? MW'(-comp[i]) : MW'(comp[i]);
                m2_reg[i]       <= SW'(mag_reg[i]) * SW'(mag_reg[i]);
                init_rem_reg[i] <= m2_reg[i] >> 1;
                init_bit_reg[i] <= m2_reg[i][0];
            end
            s_reg <= m2_reg[0] + m2_reg[1] + m2_reg[2];
        end
    end

    // restoring divider: m^2 * 2^(2F+2) / s, one quotient bit per stage
    for (genvar k = 0; k < QW; k++)
    begin : g_div
        logic [SW-1:0] rem_in [3];
        logic [QW-1:0] quo_in [3];
        logic [SW-1:0] s_in;
        logic [2:0]    bit_in;
        logic [SW-1:0] rem_next [3];
        logic [QW-1:0] quo_next [3];

        if (k == 0)
        begin : g_first
            always_comb
            begin
                s_in   = s_reg;
                bit_in = init_bit_reg;
                for (int i = 0; i < 3; i++)
                begin
                    rem_in[i] = init_rem_reg[i];
                    quo_in[i] = '0;
                end
            end
        end
        else
        begin : g_rest
            always_comb
            begin
                s_in   = dv_s_reg[k-1];
                bit_in = '0;
                for (int i = 0; i < 3; i++)
                begin
                    rem_in[i] = dv_rem_reg[k-1][i];
                    quo_in[i] = dv_quo_reg[k-1][i];
                end
            end
        end

        // trial subtract per component
        always_comb
        begin
            logic [SW:0] trial;
            logic [SW:0] diff;
            logic        ge;
            for (int i = 0; i < 3; i++)
            begin
                trial       = {rem_in[i], bit_in[i]};
                diff        = trial - {1'b0, s_in};
                ge          = trial >= {1'b0, s_in};
                rem_next[i] = ge ? diff[SW-1:0] : trial[SW-1:0];
                quo_next[i] = {quo_in[i][QW-2:0], ge};
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_s_reg[k] <= s_in;
                for (int i = 0; i < 3; i++)
                begin
                    dv_rem_reg[k][i] <= rem_next[i];
                    dv_quo_reg[k][i] <= quo_next[i];
                end
            end
        end
    end

    // restoring square root of the quotient, one root bit per stage
    for (genvar j = 0; j < RW; j++)
    begin : g_sqrt
        logic [SQW-1:0] rad_in  [3];
        logic [RW-1:0]  root_in [3];
        logic [RW+1:0]  rem_in  [3];
        logic [SQW-1:0] rad_next  [3];
        logic [RW-1:0]  root_next [3];
        logic [RW+1:0]  rem_next  [3];

        if (j == 0)
        begin : g_first
            always_comb
            begin
                for (int i = 0; i < 3; i++)
                begin
                    rad_in[i]  = {1'b0, dv_quo_reg[QW-1][i]};
                    root_in[i] = '0;
                    rem_in[i]  = '0;
                end
            end
        end
        else
        begin : g_rest
            always_comb
            begin
                for (int i = 0; i < 3; i++)
                begin
                    rad_in[i]  = sq_rad_reg[j-1][i];
                    root_in[i] = sq_root_reg[j-1][i];
                    rem_in[i]  = sq_rem_reg[j-1][i];
                end
            end
        end

        // bring down two radicand bits and try root*4+1
        always_comb
        begin
            logic [RW+1:0] rem_sh;
            logic [RW+1:0] trial;
            logic          ge;
            for (int i = 0; i < 3; i++)
            begin
                rem_sh       = {rem_in[i][RW-1:0], rad_in[i][SQW-1:SQW-2]};
                trial        = {root_in[i], 2'b01};
                ge           = rem_sh >= trial;
                rem_next[i]  = ge ? (rem_sh - trial) : rem_sh;
                root_next[i] = {root_in[i][RW-2:0], ge};
                rad_next[i]  = rad_in[i] << 2;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    sq_rad_reg[j][i]  <= rad_next[i];
                    sq_root_reg[j][i] <= root_next[i];
                    sq_rem_reg[j][i]  <= rem_next[i];
                end
            end
        end
    end

    // round to nearest: largest q with 2q-1 <= root, then apply sign; a zero-length input gives zero
    always_comb
    begin
        logic [RW:0]          qsum;
        logic [EW-1:0]        qext;
        logic [OUT_WIDTH-1:0] val [3];
        for (int i = 0; i < 3; i++)
        begin
            qsum   = {1'b0, sq_root_reg[RW-1][i]} + (RW+1)'(1);
            qext   = EW'(qsum[RW:1]);
            qext   = ctrl_reg[NST-1].neg[i] ? (EW'(0) - qext) : qext;
            val[i] = ctrl_reg[NST-1].zero ? '0 : qext[OUT_WIDTH-1:0];
        end
        res_data_next.unit_x      = val[0];
        res_data_next.unit_y      = val[1];
        res_data_next.unit_z      = val[2];
        res_data_next.zero_length = ctrl_reg[NST-1].zero;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            res_valid_reg <= ctrl_reg[NST-1].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && ctrl_reg[NST-1].valid)
        begin
            res_data_reg <= res_data_next;
        end
    end

    // accepted transaction enters the first stage
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        src_valid && src_ready |=> ctrl_reg[0].valid)
        else $error("accepted transaction missing from first stage");

    // divider remainder of the x component stays below the divisor
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_reg[SQ0-1].valid && !ctrl_reg[SQ0-1].zero
        |-> dv_rem_reg[QW-1][0] < dv_s_reg[QW-1])
        else $error("divider remainder not below divisor");

    // square root remainder of the x component bounded by twice the root
    a_sqrt_rem: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_reg[NST-1].valid
        |-> sq_rem_reg[RW-1][0] <= {sq_root_reg[RW-1][0], 1'b0})
        else $error("square root remainder out of range");

    // zero-length result carries zero components
    a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.zero_length
        |-> res_data.unit_x == '0 && res_data.unit_y == '0 && res_data.unit_z == '0)
        else $error("zero-length result with nonzero components");

endmodule
